// ===== design/urb485_pkg.sv =====
package urb485_pkg;

    typedef enum logic [1:0] {
        OP_RX_BYTE  = 2'd0,
        OP_READ     = 2'd1,
        OP_WRITE    = 2'd2,
        OP_TX_DONE  = 2'd3
    } t_opcode;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] received_byte;
        logic       receive_error;
        logic [7:0] send_byte;
        logic       line_idle;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] read_data;
        logic       read_valid;
        logic [7:0] line_byte;
        logic       line_valid;
        logic       write_accepted;
        logic       driver_on;
        logic       overflow_seen;
        logic [6:0] receive_level;
        logic [6:0] transmit_level;
    } t_out_beat;

    typedef struct packed {
        logic       read_valid;
        logic       line_valid;
        logic       line_from_store;
        logic [7:0] line_byte;
        logic       write_accepted;
        logic       driver_on;
        logic       overflow_seen;
        logic [6:0] receive_level;
        logic [6:0] transmit_level;
    } t_res_ctl;

endpackage

// ===== design/uart_ring_buffer_rs485_unit.sv =====
// Receive and transmit byte rings with RS485 driver-enable control. Each input
// beat is one event (byte received, read, write, transmit complete) and yields
// exactly one result beat. One beat is taken every clock while the input stall is low;
// a result appears in the cycle after its event is taken, because the ring stores are
// read through a registered read port that is loaded together with the result register.
// Input stall rises only while a result is held and the output side stalls.
// Ring contents come up undefined after reset and need no clearing pass;
// pointers, levels, the overflow flag and the driver enable reset at once.
module uart_ring_buffer_rs485_unit #(
    parameter int RX_DEPTH = 64,
    parameter int TX_DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  urb485_pkg::t_in_beat i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output urb485_pkg::t_out_beat o_data
);

    localparam int RXPW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int TXPW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int RXCW = $clog2(RX_DEPTH + 1);
    localparam int TXCW = $clog2(TX_DEPTH + 1);
    localparam logic [RXPW-1:0] RX_LAST = RXPW'(RX_DEPTH - 1);
    localparam logic [TXPW-1:0] TX_LAST = TXPW'(TX_DEPTH - 1);
    localparam logic [RXCW-1:0] RX_FULL = RXCW'(RX_DEPTH);
    localparam logic [TXCW-1:0] TX_FULL = TXCW'(TX_DEPTH);

    logic [7:0] rx_mem [RX_DEPTH];
    logic [7:0] tx_mem [TX_DEPTH];

    logic [RXPW-1:0] r_rx_wr_ptr, n_rx_wr_ptr;
    logic [RXPW-1:0] r_rx_rd_ptr, n_rx_rd_ptr;
    logic [RXCW-1:0] r_rx_cnt, n_rx_cnt;
    logic [TXPW-1:0] r_tx_wr_ptr, n_tx_wr_ptr;
    logic [TXPW-1:0] r_tx_rd_ptr, n_tx_rd_ptr;
    logic [TXCW-1:0] r_tx_cnt, n_tx_cnt;
    logic            r_ovf, n_ovf;
    logic            r_drv, n_drv;
    logic            r_mode;
    logic            r_res_vld;
    urb485_pkg::t_res_ctl r_res, n_res;
    logic [7:0]      r_rx_q;
    logic [7:0]      r_tx_q;

    logic advance;
    logic take;
    logic rx_we;
    logic tx_we;

    assign advance = !(r_res_vld && i_stall);
    assign take    = i_valid && advance;
    assign o_stall = !advance;

    always_comb begin
        n_rx_wr_ptr = r_rx_wr_ptr;
        n_rx_rd_ptr = r_rx_rd_ptr;
        n_rx_cnt    = r_rx_cnt;
        n_tx_wr_ptr = r_tx_wr_ptr;
        n_tx_rd_ptr = r_tx_rd_ptr;
        n_tx_cnt    = r_tx_cnt;
        n_ovf       = r_ovf;
        n_drv       = r_drv;
        rx_we       = 1'b0;
        tx_we       = 1'b0;
        n_res       = '0;

        unique case (urb485_pkg::t_opcode'(i_data.opcode))
            urb485_pkg::OP_RX_BYTE: begin
                if (!i_data.receive_error) begin
                    rx_we       = 1'b1;
                    n_rx_wr_ptr = (r_rx_wr_ptr == RX_LAST) ? '0 : r_rx_wr_ptr + 1'b1;
                    if (r_rx_cnt + 1'b1 == RX_FULL) begin
                        n_rx_cnt = '0;
                        n_ovf    = 1'b1;
                    end else begin
                        n_rx_cnt = r_rx_cnt + 1'b1;
                    end
                end
            end
            urb485_pkg::OP_READ: begin
                if (r_rx_cnt != '0) begin
                    n_res.read_valid = 1'b1;
                    n_rx_rd_ptr = (r_rx_rd_ptr == RX_LAST) ? '0 : r_rx_rd_ptr + 1'b1;
                    n_rx_cnt    = r_rx_cnt - 1'b1;
                end
            end
            urb485_pkg::OP_WRITE: begin
                if (r_tx_cnt < TX_FULL) begin
                    n_res.write_accepted = 1'b1;
                    if (r_tx_cnt != '0 || !i_data.line_idle) begin
                        tx_we       = 1'b1;
                        n_tx_wr_ptr = (r_tx_wr_ptr == TX_LAST) ? '0 : r_tx_wr_ptr + 1'b1;
                        n_tx_cnt    = r_tx_cnt + 1'b1;
                    end else begin
                        n_res.line_valid = 1'b1;
                        n_res.line_byte  = i_data.send_byte;
                        if (r_mode) begin
                            n_drv = 1'b1;
                        end
                    end
                end
            end
            urb485_pkg::OP_TX_DONE: begin
                if (r_tx_cnt != '0) begin
                    n_res.line_valid      = 1'b1;
                    n_res.line_from_store = 1'b1;
                    n_tx_cnt    = r_tx_cnt - 1'b1;
                    n_tx_rd_ptr = (r_tx_rd_ptr == TX_LAST) ? '0 : r_tx_rd_ptr + 1'b1;
                end else if (r_mode) begin
                    n_rx_wr_ptr = '0;
                    n_rx_rd_ptr = '0;
                    n_rx_cnt    = '0;
                    n_drv       = 1'b0;
                end
            end
            default: begin
            end
        endcase

        n_res.driver_on      = n_drv;
        n_res.overflow_seen  = n_ovf;
        n_res.receive_level  = 7'(n_rx_cnt);
        n_res.transmit_level = 7'(n_tx_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_wr_ptr <= '0;
            r_rx_rd_ptr <= '0;
            r_rx_cnt    <= '0;
            r_tx_wr_ptr <= '0;
            r_tx_rd_ptr <= '0;
            r_tx_cnt    <= '0;
            r_ovf       <= 1'b0;
            r_drv       <= 1'b0;
            r_mode      <= 1'b1;
            r_res_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (advance) begin
                r_res_vld <= i_valid;
            end
            if (take) begin
                r_rx_wr_ptr <= n_rx_wr_ptr;
                r_rx_rd_ptr <= n_rx_rd_ptr;
                r_rx_cnt    <= n_rx_cnt;
                r_tx_wr_ptr <= n_tx_wr_ptr;
                r_tx_rd_ptr <= n_tx_rd_ptr;
                r_tx_cnt    <= n_tx_cnt;
                r_ovf       <= n_ovf;
                r_drv       <= n_drv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && rx_we) begin
            rx_mem[r_rx_wr_ptr] <= i_data.received_byte;
        end
        if (take) begin
            r_rx_q <= rx_mem[r_rx_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && tx_we) begin
            tx_mem[r_tx_wr_ptr] <= i_data.send_byte;
        end
        if (take) begin
            r_tx_q <= tx_mem[r_tx_rd_ptr];
        end
    end

    assign o_valid = r_res_vld;

    always_comb begin
        o_data                = '0;
        o_data.read_valid     = r_res.read_valid;
        o_data.read_data      = r_res.read_valid ? r_rx_q : 8'd0;
        o_data.line_valid     = r_res.line_valid;
        o_data.line_byte      = r_res.line_from_store ? r_tx_q : r_res.line_byte;
        o_data.write_accepted = r_res.write_accepted;
        o_data.driver_on      = r_res.driver_on;
        o_data.overflow_seen  = r_res.overflow_seen;
        o_data.receive_level  = r_res.receive_level;
        o_data.transmit_level = r_res.transmit_level;
    end

`ifndef SYNTHESIS
    a_rx_level_below_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_cnt < RX_FULL)
        else $error("receive level reached depth");

    a_tx_level_within_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_cnt <= TX_FULL)
        else $error("transmit level exceeds depth");

    a_overflow_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |=> r_ovf)
        else $error("overflow flag cleared");

    a_driver_stays_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_mode && !r_drv) |=> !r_drv)
        else $error("driver enable raised outside RS485 mode");

    a_result_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_vld && r_res.read_valid) |-> (!r_res.line_valid && !r_res.write_accepted))
        else $error("read result mixed with transmit result");
`endif

endmodule
